FILE: rtl/core/bpra_pkg.sv
// ----------------------------------------------------------------------------
// bpra_pkg
// shared types and codes of the bitmap page run allocator
// ----------------------------------------------------------------------------
package bpra_pkg;

  localparam int COUNT_W  = 11;
  localparam int STATUS_W = 2;

  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [0:0]          cfg_index_t;

  localparam status_t ST_OK           = 2'd0;
  localparam status_t ST_NO_SPACE     = 2'd1;
  localparam status_t ST_OUT_OF_RANGE = 2'd2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam cfg_index_t CFG_AREA_PAGES = 1'b0;
  localparam cfg_index_t CFG_AREA_BASE  = 1'b1;

  localparam count_t AREA_PAGES_RESET = 11'd1024;

endpackage

FILE: rtl/core/bpra_page_map.sv
// ----------------------------------------------------------------------------
// bpra_page_map
// one bit per page, synchronous read, cleared by a sweep after reset
// ----------------------------------------------------------------------------
module bpra_page_map #(
  parameter int DEPTH = 1024,
  parameter int IW    = 10
) (
  input  logic          clk,
  input  logic          rst,
  output logic          busy,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_addr,
  output logic          rd_bit,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_addr,
  input  logic          wr_bit
);

  logic          mem [DEPTH];
  logic          clr_active;
  logic [IW-1:0] clr_addr;

  assign busy = clr_active;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == IW'(DEPTH - 1)) begin
        clr_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_active) begin
      mem[clr_addr] <= 1'b0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_bit;
    end
    if (rd_en) begin
      rd_bit <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/bitmap_page_run_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_page_run_allocator
// next-fit allocator of page runs over a used/free bitmap of a virtual area
// ----------------------------------------------------------------------------
// channel  | direction | handshake          | payload
// request  | in        | in_valid/in_stall   | command, num_pages, free_address
// result   | out       | out_valid/out_stall | status, run_address, pages_in_use
// config   | in        | cfg_write           | cfg_index, cfg_data
//
// allocate: one bitmap read per cycle, up to two passes over the area, then
// the run is marked page by page and its address is computed
// free: a constant reciprocal multiply for the page index, then the run is
// cleared page by page and the count of pages in use is lowered
// after reset the bitmap is swept clear of all MAX_PAGES pages, requests stall
// a new request is taken while the previous result still waits on out_stall
// ----------------------------------------------------------------------------
module bitmap_page_run_allocator #(
  parameter int MAX_PAGES  = 1024,
  parameter int PAGE_BYTES = 4096,
  parameter int ADDR_BITS  = 48
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  bpra_pkg::cfg_index_t    cfg_index,
  input  logic [ADDR_BITS-1:0]    cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    command,
  input  bpra_pkg::count_t        num_pages,
  input  logic [ADDR_BITS-1:0]    free_address,
  output logic                    out_valid,
  input  logic                    out_stall,
  output bpra_pkg::status_t       status,
  output logic [ADDR_BITS-1:0]    run_address,
  output bpra_pkg::count_t        pages_in_use
);

  import bpra_pkg::*;

  localparam int PW    = $clog2(MAX_PAGES + 1);
  localparam int IW    = $clog2(MAX_PAGES);
  localparam int NW    = (PW > COUNT_W) ? PW : COUNT_W;
  localparam int SW    = ADDR_BITS + 2;
  localparam int PG_SH = $clog2(PAGE_BYTES);
  localparam int OFS_W = IW + PG_SH;
  localparam int RCP_W = OFS_W + 2;
  localparam int FPW   = OFS_W + RCP_W;
  localparam int QSH   = OFS_W + PG_SH;

  // page index = (offset * RECIP) >> QSH, exact over the whole area
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'((((64'd1 << QSH) - 64'd1) / 64'(PAGE_BYTES)) + 64'd1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_MARK  = 4'd2;
  localparam logic [3:0] S_AMUL  = 4'd3;
  localparam logic [3:0] S_AADD  = 4'd4;
  localparam logic [3:0] S_FSPAN = 4'd5;
  localparam logic [3:0] S_FCHK  = 4'd6;
  localparam logic [3:0] S_FDIV  = 4'd7;
  localparam logic [3:0] S_FCLR  = 4'd8;
  localparam logic [3:0] S_FUPD  = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0]           state;
  count_t               area_pages;
  logic [ADDR_BITS-1:0] area_base;
  logic [NW-1:0]        used_count;
  logic [PW-1:0]        next_hint;

  count_t               cnt_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic [PW-1:0]        limit_q;

  logic [PW-1:0]        issue_ptr;
  logic                 dvld;
  logic [IW-1:0]        didx;
  logic [NW-1:0]        run;
  logic [IW-1:0]        head;
  logic                 pass2;
  logic [IW-1:0]        first;
  logic [PW-1:0]        ptr;
  count_t               left;

  logic [SW-1:0]        prod;
  logic [SW-1:0]        span;
  logic [ADDR_BITS-1:0] offset;
  logic                 below;
  logic [FPW-1:0]       fprod;
  logic [PW-1:0]        fpage;

  status_t              res_status;
  logic [ADDR_BITS-1:0] res_addr;

  logic                 map_busy;
  logic                 rd_en;
  logic                 rd_bit;
  logic                 wr_en;
  logic                 wr_bit;

  logic                 accept;
  logic [PW-1:0]        live_limit;
  logic [NW-1:0]        cnt_ext;
  logic [NW-1:0]        run_inc;
  logic                 issue_more;
  logic                 found_now;
  logic                 pass_end;
  logic [IW-1:0]        found_first;
  logic [NW:0]          used_sum;
  logic                 clr_more;
  logic                 out_load;

  bpra_page_map #(
    .DEPTH (MAX_PAGES),
    .IW    (IW)
  ) u_map (
    .clk     (clk),
    .rst     (rst),
    .busy    (map_busy),
    .rd_en   (rd_en),
    .rd_addr (issue_ptr[IW-1:0]),
    .rd_bit  (rd_bit),
    .wr_en   (wr_en),
    .wr_addr (ptr[IW-1:0]),
    .wr_bit  (wr_bit)
  );

  assign in_stall   = (state != S_IDLE) || map_busy;
  assign accept     = in_valid && !in_stall;
  assign live_limit = (NW'(area_pages) > NW'(MAX_PAGES)) ? PW'(MAX_PAGES) : PW'(area_pages);
  assign cnt_ext    = NW'(cnt_q);
  assign run_inc    = run + 1'b1;
  assign issue_more = issue_ptr < limit_q;
  assign found_now  = dvld && !rd_bit && (run_inc == cnt_ext);
  assign pass_end   = !dvld && !issue_more;
  assign found_first = (run == '0) ? didx : head;
  assign used_sum   = (NW+1)'(used_count) + (NW+1)'(cnt_q);
  assign clr_more   = (left != '0) && (ptr < limit_q);
  assign out_load   = (state == S_DONE) && (!out_valid || !out_stall);

  assign rd_en  = (state == S_SCAN) && issue_more && !found_now;
  assign wr_en  = (state == S_MARK) || ((state == S_FCLR) && clr_more);
  assign wr_bit = (state == S_MARK);

  always_ff @(posedge clk) begin
    if (rst) begin
      area_pages <= AREA_PAGES_RESET;
      area_base  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_AREA_PAGES: area_pages <= cfg_data[COUNT_W-1:0];
        CFG_AREA_BASE:  area_base  <= cfg_data;
        default:        area_base  <= area_base;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used_count <= '0;
      next_hint  <= '0;
      dvld       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid    <= 1'b1;
        status       <= res_status;
        run_address  <= res_addr;
        pages_in_use <= used_count[COUNT_W-1:0];
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cnt_q   <= num_pages;
            addr_q  <= free_address;
            limit_q <= live_limit;
            if (command == CMD_FREE) begin
              state <= S_FSPAN;
            end else if (num_pages == '0) begin
              res_status <= ST_NO_SPACE;
              res_addr   <= '0;
              state      <= S_DONE;
            end else begin
              issue_ptr <= next_hint;
              pass2     <= 1'b0;
              run       <= '0;
              dvld      <= 1'b0;
              state     <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (rd_en) begin
            issue_ptr <= issue_ptr + 1'b1;
            didx      <= issue_ptr[IW-1:0];
            dvld      <= 1'b1;
          end else begin
            dvld <= 1'b0;
          end
          if (dvld) begin
            if (!rd_bit) begin
              if (run == '0) begin
                head <= didx;
              end
              run <= run_inc;
            end else begin
              run <= '0;
            end
          end
          if (found_now) begin
            first <= found_first;
            ptr   <= PW'(found_first);
            left  <= cnt_q;
            state <= S_MARK;
          end else if (pass_end) begin
            if (!pass2) begin
              pass2     <= 1'b1;
              issue_ptr <= '0;
              run       <= '0;
            end else begin
              res_status <= ST_NO_SPACE;
              res_addr   <= '0;
              state      <= S_DONE;
            end
          end
        end
        S_MARK: begin
          ptr  <= ptr + 1'b1;
          left <= left - 1'b1;
          if (left == count_t'(1)) begin
            used_count <= (used_sum > (NW+1)'(MAX_PAGES)) ? NW'(MAX_PAGES) : used_sum[NW-1:0];
            next_hint  <= PW'(NW'(first) + cnt_ext);
            state      <= S_AMUL;
          end
        end
        S_AMUL: begin
          prod  <= SW'(first) * SW'(PAGE_BYTES);
          state <= S_AADD;
        end
        S_AADD: begin
          res_addr   <= area_base + prod[ADDR_BITS-1:0];
          res_status <= ST_OK;
          state      <= S_DONE;
        end
        S_FSPAN: begin
          below  <= addr_q < area_base;
          offset <= addr_q - area_base;
          span   <= SW'(limit_q) * SW'(PAGE_BYTES);
          state  <= S_FCHK;
        end
        S_FCHK: begin
          if (below || (SW'(offset) >= span)) begin
            res_status <= ST_OUT_OF_RANGE;
            res_addr   <= '0;
            state      <= S_DONE;
          end else begin
            fprod <= FPW'(offset[OFS_W-1:0]) * FPW'(RECIP);
            state <= S_FDIV;
          end
        end
        S_FDIV: begin
          fpage <= fprod[QSH +: PW];
          ptr   <= fprod[QSH +: PW];
          left  <= cnt_q;
          state <= S_FCLR;
        end
        S_FCLR: begin
          if (clr_more) begin
            ptr  <= ptr + 1'b1;
            left <= left - 1'b1;
          end else begin
            state <= S_FUPD;
          end
        end
        S_FUPD: begin
          used_count <= (used_count > cnt_ext) ? used_count - cnt_ext : '0;
          if (fpage < next_hint) begin
            next_hint <= fpage;
          end
          res_status <= ST_OK;
          res_addr   <= '0;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
